### src/circular_queue_with_search_defines.svh
// Assertion helpers used by the queue RTL.
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CQS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define CQS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### src/cqs_pkg.sv
package cqs_pkg;

    localparam int DEPTH   = 8;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;
    localparam int POS_MAX = 2 ** POS_W - 1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_DELETE,
        CMD_SEARCH,
        CMD_DISPLAY
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY,
        ST_NOTFOUND
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DATA
    } t_state;

    // Circular increment of a slot index.
    function automatic t_addr next_slot(t_addr i);
        return (i == t_addr'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

### src/cqs_if.sv
interface cqs_in_if import cqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface cqs_out_if import cqs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         position;
    logic                     last;

    modport source (output valid, output status, output data, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input data, input position,
                    input last, output ready);
endinterface

### src/cqs_ram.sv
module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/circular_queue_with_search.sv
// Circular FIFO of signed 32-bit words with linear search and dump.
// i_in carries one command beat (cmd, value): insert, delete, search or
// display. o_out returns result beats (status, data, position, last);
// every command gives one beat, except display of a non-empty queue,
// which gives one beat per stored word, oldest first, last set on the end.
// Insert, and any command on an empty queue, answer from the start state;
// delete, search and display first read the RAM and answer from the data
// state. A search compares up to DEPTH entries; display gives one beat per
// cycle while the receiver is ready. ready comes back the cycle after the
// final load.
// The storage RAM has one registered read port, so the search and display
// walk visit one slot per cycle unless stalled; i_in.ready is high only
// while the sequencer is idle, and the next command can be taken while the
// final beat of the previous one still waits in the output register.
// A stalled receiver holds the output beat; the walk waits for it.
// Reset (synchronous, active low) empties the queue and drops any pending
// beat; storage contents are left as they are and only written slots are
// ever read.
`include "circular_queue_with_search_defines.svh"

module circular_queue_with_search import cqs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cqs_in_if.sink     i_in,
    cqs_out_if.source  o_out
);

    // Sequencer and queue state.
    t_state                   r_state, n_state;
    t_addr                    r_head, n_head;
    t_addr                    r_tail, n_tail;
    logic                     r_empty, n_empty;

    // Walk registers and latched command.
    t_cmd                     r_cmd;
    logic signed [DATA_W-1:0] r_key;
    t_addr                    r_slot, n_slot;
    t_addr                    r_cnt, n_cnt;

    // Output register.
    logic                     r_ov;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_data;
    logic [POS_W-1:0]         r_pos;
    logic                     r_last;

    // Shared decisions.
    logic                     w_accept;
    logic                     w_free;
    logic                     w_full;
    logic                     w_at_end;
    logic                     w_match;
    logic [ADDR_W:0]          w_pos_ext;

    // Beat to load and RAM controls.
    logic                     w_emit;
    t_status                  w_status;
    logic signed [DATA_W-1:0] w_data;
    logic [POS_W-1:0]         w_pos;
    logic                     w_last;
    logic                     w_we;
    t_addr                    w_waddr;
    logic                     w_re;
    t_addr                    w_raddr;
    logic [DATA_W-1:0]        w_rdata;

    // Output beat that carries a search position.
    logic                     w_pos_beat;

    cqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_key),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_free     = !r_ov || o_out.ready;
    assign w_full     = !r_empty && (r_head == next_slot(r_tail));
    // Walk ends at the tail; the count bound only backs that up.
    assign w_at_end   = (r_slot == r_tail) || (r_cnt == t_addr'(DEPTH - 1));
    assign w_match    = ($signed(w_rdata) == r_key);
    assign w_pos_ext  = {1'b0, r_cnt} + 1'b1;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if ((r_cmd == CMD_INSERT) || r_empty) begin
                    if (w_free) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_DATA;
                end
            end
            S_DATA: begin
                unique case (r_cmd)
                    CMD_DELETE: begin
                        if (w_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_SEARCH: begin
                        if ((w_match || w_at_end) && w_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_DISPLAY: begin
                        if (w_at_end && w_free) begin
                            n_state = S_IDLE;
                        end
                    end
                    CMD_INSERT: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb begin
        w_emit   = 1'b0;
        w_status = ST_OK;
        w_data   = '0;
        w_pos    = '0;
        w_last   = 1'b1;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_re     = 1'b0;
        w_raddr  = r_slot;
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot = r_head;
                    n_cnt  = '0;
                end
            end
            S_START: begin
                if (r_cmd == CMD_INSERT) begin
                    if (w_free) begin
                        w_emit = 1'b1;
                        if (r_empty) begin
                            // first word restarts at slot 0
                            w_we    = 1'b1;
                            w_waddr = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b0;
                        end else if (w_full) begin
                            w_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = next_slot(r_tail);
                            n_tail  = next_slot(r_tail);
                        end
                    end
                end else if (r_empty) begin
                    if (w_free) begin
                        w_emit   = 1'b1;
                        w_status = ST_EMPTY;
                    end
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_slot;
                end
            end
            S_DATA: begin
                unique case (r_cmd)
                    CMD_DELETE: begin
                        if (w_free) begin
                            w_emit = 1'b1;
                            w_data = $signed(w_rdata);
                            if (r_head == r_tail) begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_empty = 1'b1;
                            end else begin
                                n_head = next_slot(r_head);
                            end
                        end
                    end
                    CMD_SEARCH: begin
                        if (w_match) begin
                            if (w_free) begin
                                w_emit = 1'b1;
                                w_pos  = (32'(w_pos_ext) > POS_MAX) ?
                                         POS_W'(POS_MAX) : POS_W'(w_pos_ext);
                            end
                        end else if (w_at_end) begin
                            if (w_free) begin
                                w_emit   = 1'b1;
                                w_status = ST_NOTFOUND;
                            end
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = next_slot(r_slot);
                            n_slot  = next_slot(r_slot);
                            n_cnt   = r_cnt + 1'b1;
                        end
                    end
                    CMD_DISPLAY: begin
                        if (w_free) begin
                            w_emit = 1'b1;
                            w_data = $signed(w_rdata);
                            w_last = w_at_end;
                            if (!w_at_end) begin
                                w_re    = 1'b1;
                                w_raddr = next_slot(r_slot);
                                n_slot  = next_slot(r_slot);
                                n_cnt   = r_cnt + 1'b1;
                            end
                        end
                    end
                    CMD_INSERT: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= t_cmd'(i_in.cmd);
            r_key <= i_in.value;
        end
        r_slot <= n_slot;
        r_cnt  <= n_cnt;
        if (w_emit) begin
            r_status <= w_status;
            r_data   <= w_data;
            r_pos    <= w_pos;
            r_last   <= w_last;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.status   = r_status;
    assign o_out.data     = r_data;
    assign o_out.position = r_pos;
    assign o_out.last     = r_last;

    assign w_pos_beat = o_out.valid && (o_out.position != '0);

    `CQS_ASSERT_RST(a_rst_idle, !i_rst_n |=> !o_out.valid && i_in.ready, "reset left work")
    `CQS_ASSERT(a_empty_idx, r_empty |-> (r_head == '0) && (r_tail == '0), "empty, idx set")
    `CQS_ASSERT(a_accept_start, (i_in.valid && i_in.ready) |=> (r_state == S_START), "no start")
    `CQS_ASSERT(a_emit_free, w_emit |-> (!r_ov || o_out.ready), "beat overwritten")
    `CQS_ASSERT(a_pos_ok, w_pos_beat |-> (o_out.status == ST_OK) && (o_out.data == '0), "pos beat")

endmodule
